// ===== rtl/core/snsf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snsf_pkg: shared types and constants of the noise-sharpening filter
// Sample, coefficient and product widths, lane control codes and the
// saturation helpers used by the channel lanes.
// ----------------------------------------------------------------------------
package snsf_pkg;

  localparam int SampleW  = 24;
  localparam int CarryW   = SampleW + 4;
  localparam int GainW    = 18;
  localparam int CoefW    = 19;
  localparam int GainFrac = 14;
  localparam int CoefFrac = 17;

  // Serial multiplier: the multiplicand is a sample difference or an emphasised
  // sample, the multiplier is a gain or coefficient sign-extended to MplierW.
  localparam int McandW   = SampleW + 1;
  localparam int MplierW  = CoefW + 1;
  localparam int HiW      = McandW + 1;
  localparam int AccW     = HiW + 1;
  localparam int ProdW    = HiW + MplierW;
  localparam int WideW    = ProdW + 1;
  localparam int StepCntW = $clog2(MplierW);

  localparam int DataW    = ((2 * SampleW + 7) / 8) * 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam logic [GainW-1:0] GainRst       = '0;
  localparam logic [CoefW-1:0] CoefDirectRst = 19'h20000;
  localparam logic [CoefW-1:0] CoefCarryRst  = '0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EMPHASIS_GAIN = 3'd0,
    CFG_COEF_DIRECT   = 3'd1,
    CFG_COEF_CARRY_B  = 3'd2,
    CFG_COEF_CARRY_A  = 3'd3
  } cfg_index_e;

  typedef enum logic [2:0] {
    OP_IDLE   = 3'd0,
    OP_START  = 3'd1,
    OP_STEP   = 3'd2,
    OP_EMPH   = 3'd3,
    OP_DIRECT = 3'd4,
    OP_CARRY  = 3'd5
  } lane_op_e;

  typedef struct packed {
    lane_op_e op;
    logic     sign_step;
  } lane_ctrl_t;

  function automatic logic [SampleW-1:0] sat_sample(input logic signed [WideW-1:0] v);
    logic [WideW-SampleW:0] top_bits;
    top_bits = v[WideW-1:SampleW-1];
    priority if (&top_bits || ~|top_bits) begin
      return v[SampleW-1:0];
    end else if (v[WideW-1]) begin
      return {1'b1, {(SampleW-1){1'b0}}};
    end else begin
      return {1'b0, {(SampleW-1){1'b1}}};
    end
  endfunction

  function automatic logic [CarryW-1:0] sat_carry(input logic signed [WideW-1:0] v);
    logic [WideW-CarryW:0] top_bits;
    top_bits = v[WideW-1:CarryW-1];
    priority if (&top_bits || ~|top_bits) begin
      return v[CarryW-1:0];
    end else if (v[WideW-1]) begin
      return {1'b1, {(CarryW-1){1'b0}}};
    end else begin
      return {1'b0, {(CarryW-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/snsf_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snsf_lane: one channel of the noise-sharpening filter
// Holds the channel state and a bit-serial shift-add multiplier that retires
// one multiplier bit per cycle; the sequencer in the top level drives it.
// ----------------------------------------------------------------------------
module snsf_lane (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire  snsf_pkg::lane_ctrl_t      ctrl_i,
  input  wire  [snsf_pkg::SampleW-1:0]    sample_i,
  input  wire  [snsf_pkg::MplierW-1:0]    gain_i,
  input  wire  [snsf_pkg::MplierW-1:0]    coef_direct_i,
  input  wire  [snsf_pkg::MplierW-1:0]    coef_sum_i,
  output logic [snsf_pkg::SampleW-1:0]    y_o
);

  logic [snsf_pkg::SampleW-1:0] last_q, last_d;
  logic [snsf_pkg::CarryW-1:0]  carry_q, carry_d;
  logic [snsf_pkg::SampleW-1:0] x_q, x_d;
  logic [snsf_pkg::SampleW-1:0] y_q, y_d;
  logic [snsf_pkg::McandW-1:0]  mcand_q, mcand_d;
  logic [snsf_pkg::HiW-1:0]     hi_q, hi_d;
  logic [snsf_pkg::MplierW-1:0] lo_q, lo_d;

  logic signed [snsf_pkg::ProdW-1:0] prod;
  logic signed [snsf_pkg::AccW-1:0]  hi_ext, mc_ext, addend, step_sum;
  logic signed [snsf_pkg::WideW-1:0] emph_sum, direct_sum, carry_sum;

  always_comb begin
    prod   = {hi_q, lo_q};
    hi_ext = {hi_q[snsf_pkg::HiW-1], hi_q};
    mc_ext = snsf_pkg::AccW'(signed'(mcand_q));
    // The multiplier's sign bit carries negative weight, so its step subtracts.
    addend   = ctrl_i.sign_step ? -mc_ext : mc_ext;
    step_sum = hi_ext + (lo_q[0] ? addend : '0);

    // Rounding half up is the truncated product plus the first dropped bit.
    emph_sum   = snsf_pkg::WideW'(signed'(x_q))
               + snsf_pkg::WideW'(prod >>> snsf_pkg::GainFrac)
               + snsf_pkg::WideW'(prod[snsf_pkg::GainFrac-1]);
    direct_sum = snsf_pkg::WideW'(signed'(carry_q))
               + snsf_pkg::WideW'(prod >>> snsf_pkg::CoefFrac)
               + snsf_pkg::WideW'(prod[snsf_pkg::CoefFrac-1]);
    carry_sum  = snsf_pkg::WideW'(prod >>> snsf_pkg::CoefFrac)
               + snsf_pkg::WideW'(prod[snsf_pkg::CoefFrac-1]);

    last_d  = last_q;
    carry_d = carry_q;
    x_d     = x_q;
    y_d     = y_q;
    mcand_d = mcand_q;
    hi_d    = hi_q;
    lo_d    = lo_q;

    unique case (ctrl_i.op)
      snsf_pkg::OP_START: begin
        x_d     = sample_i;
        mcand_d = snsf_pkg::McandW'(signed'(sample_i))
                - snsf_pkg::McandW'(signed'(last_q));
        hi_d    = '0;
        lo_d    = gain_i;
      end
      snsf_pkg::OP_STEP: begin
        hi_d = step_sum[snsf_pkg::HiW:1];
        lo_d = {step_sum[0], lo_q[snsf_pkg::MplierW-1:1]};
      end
      snsf_pkg::OP_EMPH: begin
        mcand_d = snsf_pkg::McandW'(signed'(snsf_pkg::sat_sample(emph_sum)));
        hi_d    = '0;
        lo_d    = coef_direct_i;
      end
      snsf_pkg::OP_DIRECT: begin
        y_d  = snsf_pkg::sat_sample(direct_sum);
        hi_d = '0;
        lo_d = coef_sum_i;
      end
      snsf_pkg::OP_CARRY: begin
        carry_d = snsf_pkg::sat_carry(carry_sum);
        last_d  = x_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      carry_q <= '0;
    end else begin
      last_q  <= last_d;
      carry_q <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    mcand_q <= mcand_d;
    hi_q    <= hi_d;
    lo_q    <= lo_d;
  end

  assign y_o = y_q;

endmodule
`default_nettype wire

// ===== rtl/core/stereo_noise_sharpening_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_noise_sharpening_filter: emphasis plus first-order section, stereo
// Each frame runs through two identical lanes with bit-serial multipliers.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Contents
//  s_axis    in         s_axis_tvalid/tready       stereo frame, tlast = block end
//  m_axis    out        m_axis_tvalid/tready       processed frame, tlast copied
//  cfg       in         cfg_valid_i/cfg_ready_o    register index and write data
//
// A frame runs from the accept cycle through three serial multiplies (one
// multiplier bit a cycle in each lane), each followed by a step for rounding,
// saturation and reloading, before the next frame can be accepted.
// Reset clears the channel history and carries at once; there is no sweep.
// A result waits in the output register; the core stalls in its final step
// only if that register is still full, and accepts the next frame once idle.
// ----------------------------------------------------------------------------
module stereo_noise_sharpening_filter (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata from bit 0: left_in, right_in; no fill bits at SampleW = 24
  input  wire  [snsf_pkg::DataW-1:0]       s_axis_tdata,
  input  wire                              s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // tdata from bit 0: left_out, right_out; no fill bits at SampleW = 24
  output logic [snsf_pkg::DataW-1:0]       m_axis_tdata,
  output logic                             m_axis_tlast,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [snsf_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire  [snsf_pkg::CfgDataW-1:0]    cfg_data_i
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_MUL_D  = 7'b0000010,
    ST_EMPH   = 7'b0000100,
    ST_MUL_B  = 7'b0001000,
    ST_DIRECT = 7'b0010000,
    ST_MUL_S  = 7'b0100000,
    ST_FIN    = 7'b1000000
  } state_e;

  state_e                          state_q, state_d;
  logic [snsf_pkg::StepCntW-1:0]   cnt_q, cnt_d;
  logic                            last_q, last_d;
  logic                            out_valid_q, out_valid_d;
  logic [snsf_pkg::SampleW-1:0]    out_left_q, out_right_q;
  logic                            out_last_q;
  logic                            out_load, out_free, step_last;

  logic [snsf_pkg::GainW-1:0]      gain_q;
  logic [snsf_pkg::CoefW-1:0]      coef_direct_q, coef_carry_b_q, coef_carry_a_q;
  logic [snsf_pkg::MplierW-1:0]    gain_ext, coef_direct_ext, coef_sum;

  snsf_pkg::lane_ctrl_t            ctrl;
  logic [snsf_pkg::SampleW-1:0]    y_left, y_right;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q         <= snsf_pkg::GainRst;
      coef_direct_q  <= snsf_pkg::CoefDirectRst;
      coef_carry_b_q <= snsf_pkg::CoefCarryRst;
      coef_carry_a_q <= snsf_pkg::CoefCarryRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        snsf_pkg::CFG_EMPHASIS_GAIN: gain_q         <= cfg_data_i[snsf_pkg::GainW-1:0];
        snsf_pkg::CFG_COEF_DIRECT:   coef_direct_q  <= cfg_data_i[snsf_pkg::CoefW-1:0];
        snsf_pkg::CFG_COEF_CARRY_B:  coef_carry_b_q <= cfg_data_i[snsf_pkg::CoefW-1:0];
        snsf_pkg::CFG_COEF_CARRY_A:  coef_carry_a_q <= cfg_data_i[snsf_pkg::CoefW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign gain_ext        = snsf_pkg::MplierW'(signed'(gain_q));
  assign coef_direct_ext = snsf_pkg::MplierW'(signed'(coef_direct_q));
  assign coef_sum        = snsf_pkg::MplierW'(signed'(coef_carry_a_q))
                         + snsf_pkg::MplierW'(signed'(coef_carry_b_q));

  // Sequencer
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step_last     = (cnt_q == snsf_pkg::StepCntW'(snsf_pkg::MplierW - 1));

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    last_d         = last_q;
    out_load       = 1'b0;
    ctrl.op        = snsf_pkg::OP_IDLE;
    ctrl.sign_step = step_last;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          ctrl.op = snsf_pkg::OP_START;
          last_d  = s_axis_tlast;
          cnt_d   = '0;
          state_d = ST_MUL_D;
        end
      end
      ST_MUL_D, ST_MUL_B, ST_MUL_S: begin
        ctrl.op = snsf_pkg::OP_STEP;
        cnt_d   = cnt_q + 1'b1;
        if (step_last) begin
          cnt_d = '0;
          unique case (state_q)
            ST_MUL_D: state_d = ST_EMPH;
            ST_MUL_B: state_d = ST_DIRECT;
            default:  state_d = ST_FIN;
          endcase
        end
      end
      ST_EMPH: begin
        ctrl.op = snsf_pkg::OP_EMPH;
        state_d = ST_MUL_B;
      end
      ST_DIRECT: begin
        ctrl.op = snsf_pkg::OP_DIRECT;
        state_d = ST_MUL_S;
      end
      ST_FIN: begin
        if (out_free) begin
          ctrl.op  = snsf_pkg::OP_CARRY;
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    if (out_load) begin
      out_left_q  <= y_left;
      out_right_q <= y_right;
      out_last_q  <= last_q;
    end
  end

  snsf_lane u_lane_left (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .sample_i      (s_axis_tdata[snsf_pkg::SampleW-1:0]),
    .gain_i        (gain_ext),
    .coef_direct_i (coef_direct_ext),
    .coef_sum_i    (coef_sum),
    .y_o           (y_left)
  );

  snsf_lane u_lane_right (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .sample_i      (s_axis_tdata[2*snsf_pkg::SampleW-1:snsf_pkg::SampleW]),
    .gain_i        (gain_ext),
    .coef_direct_i (coef_direct_ext),
    .coef_sum_i    (coef_sum),
    .y_o           (y_right)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = snsf_pkg::DataW'({out_right_q, out_left_q});
  assign m_axis_tlast  = out_last_q;

  // The step counter never runs past the multiplier width.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL_D || state_q == ST_MUL_B || state_q == ST_MUL_S)
      |-> (cnt_q < snsf_pkg::StepCntW'(snsf_pkg::MplierW)))
    else $error("step counter out of range");

  // An accepted frame always starts with the difference multiply from step zero.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_MUL_D && cnt_q == '0))
    else $error("accepted frame did not start the first multiply");

  // A new result only appears after the final step of a frame.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result raised outside the final step");

  // The final step completes in the cycle the output register can take it.
  a_fin_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && (!out_valid_q || m_axis_tready)) |=> (state_q == ST_IDLE))
    else $error("final step stalled with a free output register");

endmodule
`default_nettype wire
